FILE: rtl/sdvc_pkg.sv
package sdvc_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int VAL_W     = 32;
   localparam int CNT_W     = 7;

   // one held entry of the chain
   typedef struct packed {
      logic                    valid;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic                    insert;
      logic                    drain;
      logic                    hit;
      logic                    full;
      logic signed [VAL_W-1:0] value;
   } cell_ctl_type;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ITEMS);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

endpackage

FILE: rtl/sdvc_cell.sv
module sdvc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sdvc_pkg::cell_ctl_type ctl,
   input  sdvc_pkg::entry_type  prev_entry,
   input  logic                 prev_place,
   input  sdvc_pkg::entry_type  next_entry,
   output sdvc_pkg::entry_type  entry,
   output logic                 place,
   output logic                 equal,
   output logic                 saturated
);
   import sdvc_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new word belongs at or below this cell
   assign place     = !entry_ff.valid || (entry_ff.value > ctl.value);
   assign equal     = entry_ff.valid && (entry_ff.value == ctl.value);
   assign saturated = equal && (entry_ff.count == CNT_MAX);
   assign entry     = entry_ff;

   // next entry: drain shift, count bump or insertion shift
   always_comb begin
      entry_in = entry_ff;
      if (ctl.drain) begin
         entry_in = next_entry;
      end else if (ctl.insert) begin
         if (ctl.hit) begin
            if (equal && !saturated) begin
               entry_in.count = entry_ff.count + CNT_ONE;
            end
         end else if (!ctl.full && place) begin
            if (prev_place) begin
               entry_in = prev_entry;
            end else begin
               entry_in.valid = 1'b1;
               entry_in.value = ctl.value;
               entry_in.count = CNT_ONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff.value <= entry_in.value;
      entry_ff.count <= entry_in.count;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

endmodule

FILE: rtl/sorted_distinct_value_counter.sv
// channel | direction | words
// req_    | in        | value, last_in; one word per cycle while filling
// rsp_    | out       | distinct_value, occurrences, overflow, last_out
//
// while filling, a word is taken every cycle; each cell compares it with its
// own entry and shifts one place up, so insertion is done in that cycle.
// after the last word the chain drains from its low end, one result per cycle
// when rsp_ready allows; req_ready stays low until the final result is loaded.
// reset empties the chain (cell valid bits clear).
// a stall on rsp_ holds the chain and the output register.
module sorted_distinct_value_counter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [sdvc_pkg::VAL_W-1:0] req_value,
   input  logic                             req_last_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [sdvc_pkg::VAL_W-1:0] rsp_distinct_value,
   output logic [sdvc_pkg::CNT_W-1:0]       rsp_occurrences,
   output logic                             rsp_overflow,
   output logic                             rsp_last_out
);
   import sdvc_pkg::*;

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic state_ff, state_in;
   logic drop_ff, drop_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic rsp_ovf_ff, rsp_ovf_in;
   logic rsp_last_ff, rsp_last_in;

   entry_type           entries [MAX_ITEMS];
   logic [MAX_ITEMS-1:0] places;
   logic [MAX_ITEMS-1:0] equals;
   logic [MAX_ITEMS-1:0] sats;
   cell_ctl_type        ctl;
   logic                accept;
   logic                load;
   entry_type           empty_entry;

   assign req_ready = (state_ff == ST_FILL);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);

   assign empty_entry = '0;

   // broadcast control
   always_comb begin
      ctl.insert = accept;
      ctl.drain  = load;
      ctl.hit    = |equals;
      ctl.full   = entries[MAX_ITEMS-1].valid;
      ctl.value  = req_value;
   end

   // chain of cells
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_p;
      if (i == 0) begin : g_first
         assign prev_e = empty_entry;
         assign prev_p = 1'b0;
      end else begin : g_mid
         assign prev_e = entries[i-1];
         assign prev_p = places[i-1];
      end
      if (i == MAX_ITEMS-1) begin : g_last
         assign next_e = empty_entry;
      end else begin : g_nxt
         assign next_e = entries[i+1];
      end
      sdvc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_entry (prev_e),
         .prev_place (prev_p),
         .next_entry (next_e),
         .entry      (entries[i]),
         .place      (places[i]),
         .equal      (equals[i]),
         .saturated  (sats[i])
      );
   end

   // sequencing and output register
   always_comb begin
      state_in     = state_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if ((ctl.hit && (|sats)) || (!ctl.hit && ctl.full)) begin
                  drop_in = 1'b1;
               end
               if (req_last_in) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = entries[0].value;
               rsp_count_in = entries[0].count;
               rsp_ovf_in   = drop_ff;
               rsp_last_in  = !entries[1].valid;
               if (!entries[1].valid) begin
                  state_in = ST_FILL;
                  drop_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distinct_value = rsp_value_ff;
   assign rsp_occurrences    = rsp_count_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last_out       = rsp_last_ff;

endmodule

FILE: tb/tb_sorted_distinct_value_counter.sv
`timescale 1ns / 1ps

module tb_sorted_distinct_value_counter;

   import sdvc_pkg::*;

   localparam int RANDOM_WORDS = 236;
   localparam int DIRECTED_LEN = 24;
   localparam int SIDE_REQ     = 0;
   localparam int SIDE_RSP     = 1;
   localparam int GAP_MAX      = 17;
   localparam int DRAIN_CYCLES = 20;

   localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // one result word as the block should emit it
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
      logic                    over;
      logic                    last;
   } tally_type;

   // directed stimulus row; want is used only when typed is set
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
      logic                    typed;
      tally_type               want;
   } stim_row_type;

   // value, last, typed, typed result
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // lone extremes and values around zero, each a batch of its own
      '{VAL_MIN, 1'b1, 1'b1, '{VAL_MIN, CNT_ONE, 1'b0, 1'b1}},
      '{VAL_MAX, 1'b1, 1'b1, '{VAL_MAX, CNT_ONE, 1'b0, 1'b1}},
      '{32'sd0,  1'b1, 1'b1, '{32'sd0,  CNT_ONE, 1'b0, 1'b1}},
      '{-32'sd1, 1'b1, 1'b1, '{-32'sd1, CNT_ONE, 1'b0, 1'b1}},
      // mixed batch with repeats and both extremes
      '{32'sd5,  1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd5,  1'b0, 1'b0, '0},
      '{VAL_MAX, 1'b0, 1'b0, '0},
      '{VAL_MIN, 1'b0, 1'b0, '0},
      '{-32'sd3, 1'b0, 1'b0, '0},
      '{32'sd5,  1'b1, 1'b0, '0},
      // ordering across zero
      '{-32'sd1, 1'b0, 1'b0, '0},
      '{32'sd0,  1'b0, 1'b0, '0},
      '{32'sd1,  1'b0, 1'b0, '0},
      '{32'sd0,  1'b1, 1'b0, '0},
      // alternating bit patterns near the extremes
      '{32'sh8000_0001, 1'b0, 1'b0, '0},
      '{32'sh7fff_fffe, 1'b0, 1'b0, '0},
      '{32'sh5555_5555, 1'b0, 1'b0, '0},
      '{32'shaaaa_aaaa, 1'b1, 1'b0, '0},
      // descending arrival
      '{32'sd300, 1'b0, 1'b0, '0},
      '{32'sd200, 1'b0, 1'b0, '0},
      '{32'sd100, 1'b1, 1'b0, '0},
      // one value twice
      '{32'sd7,  1'b0, 1'b0, '0},
      '{32'sd7,  1'b1, 1'b0, '0}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    req_last_in = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_distinct_value;
   logic [CNT_W-1:0]        rsp_occurrences;
   logic                    rsp_overflow;
   logic                    rsp_last_out;

   // predictor copy of the sorted table
   logic signed [VAL_W-1:0] held_value [MAX_ITEMS];
   logic [CNT_W-1:0]        held_count [MAX_ITEMS];
   int                      held_used = 0;
   logic                    held_dropped = 1'b0;

   tally_type               tally_queue [$];
   int                      mismatches = 0;
   int                      words_taken = 0;

   // idle pacing per side: runs of gapped or back-to-back words
   int                      pace_left [2] = '{0, 0};
   bit                      pace_tight [2];

   logic signed [VAL_W-1:0] pool_vals [6];

   sorted_distinct_value_counter DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_distinct_value (rsp_distinct_value),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_overflow       (rsp_overflow),
      .rsp_last_out       (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap(input int side);
      if (pace_left[side] == 0) begin
         pace_left[side]  = $urandom_range(1, 40);
         pace_tight[side] = ($urandom_range(0, 2) == 0);
      end
      pace_left[side]--;
      return pace_tight[side] ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // insert one accepted word into the table, emit the batch on last
   task automatic absorb_word(input logic signed [VAL_W-1:0] v, input logic l,
                              input bit keep);
      int        pos;
      int        i;
      tally_type r;
      pos = 0;
      while (pos < held_used && held_value[pos] < v)
         pos++;
      if (pos < held_used && held_value[pos] == v) begin
         if (held_count[pos] < CNT_MAX)
            held_count[pos]++;
         else
            held_dropped = 1'b1;
      end else if (held_used >= MAX_ITEMS) begin
         held_dropped = 1'b1;
      end else begin
         for (i = held_used; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_count[i] = held_count[i-1];
         end
         held_value[pos] = v;
         held_count[pos] = CNT_ONE;
         held_used++;
      end
      if (l) begin
         for (i = 0; i < held_used; i++) begin
            r.value = held_value[i];
            r.count = held_count[i];
            r.over  = held_dropped;
            r.last  = (i == held_used - 1);
            if (keep)
               tally_queue = {tally_queue, r};
         end
         held_used    = 0;
         held_dropped = 1'b0;
      end
   endtask

   task automatic send_word(input logic signed [VAL_W-1:0] v, input logic l,
                            input bit typed, input tally_type want);
      int gap;
      gap = draw_gap(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= v;
      req_last_in <= l;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_taken++;
      absorb_word(v, l, !typed);
      if (typed)
         tally_queue = {tally_queue, want};
   endtask

   // mostly repeats from a small pool, some extremes and wide random values
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2, 3, 4,
         5, 6:    return pool_vals[$urandom_range(0, 5)];
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin : stimulus
      int k;
      int len;
      int batch;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < DIRECTED_LEN; k++)
         send_word(DIRECTED_ROWS[k].value, DIRECTED_ROWS[k].last,
                   DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

      batch = 0;
      while (words_taken < DIRECTED_LEN + RANDOM_WORDS) begin
         if (batch == 2) begin
            // count saturates, then a repeat and the last word are dropped
            pool_vals[0] = $urandom;
            for (k = 0; k < MAX_ITEMS + 1; k++)
               send_word(pool_vals[0], 1'b0, 1'b0, '0);
            send_word(~pool_vals[0], 1'b0, 1'b0, '0);
            send_word(pool_vals[0], 1'b1, 1'b0, '0);
         end else if (batch == 5) begin
            // table fills with distinct values, then a new last word is dropped
            for (k = 0; k < MAX_ITEMS; k++) begin
               pool_vals[1] = {6'((k * 37) % MAX_ITEMS), 26'($urandom)};
               if (k == 10)
                  pool_vals[0] = pool_vals[1];
               send_word(pool_vals[1], 1'b0, 1'b0, '0);
            end
            send_word(pool_vals[0], 1'b0, 1'b0, '0);
            pool_vals[1] = $urandom;
            send_word(pool_vals[1], 1'b0, 1'b0, '0);
            send_word(pool_vals[1], 1'b1, 1'b0, '0);
         end else begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, MAX_ITEMS)
                                               : $urandom_range(1, 12);
            for (k = 0; k < 6; k++)
               pool_vals[k] = $urandom;
            for (k = 0; k < len; k++)
               send_word(pick_value(), k == len - 1, 1'b0, '0);
         end
         batch++;
      end
      req_valid <= 1'b0;

      while (tally_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && tally_queue.size() == 0)
         $display("sorted_distinct_value_counter test passed");
      else
         $display("sorted_distinct_value_counter test failed");
      $finish;
   end

   // result side: random stalls, compare each word with the oldest expectation
   initial begin : drain_results
      int        stall;
      tally_type got;
      tally_type want;
      wait (reset == 1'b0);
      forever begin
         stall = draw_gap(SIDE_RSP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.value = rsp_distinct_value;
         got.count = rsp_occurrences;
         got.over  = rsp_overflow;
         got.last  = rsp_last_out;
         if (tally_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: value %0d count %0d overflow %0b last %0b",
                        got.value, got.count, got.over, got.last);
         end else begin
            want = tally_queue.pop_front();
            if (got.value !== want.value || got.count !== want.count ||
                got.over !== want.over || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                           want.value, want.count, want.over, want.last,
                           got.value, got.count, got.over, got.last);
            end
         end
      end
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("sorted_distinct_value_counter test failed");
      $finish;
   end

endmodule
